FILE: sv/utf8_char_segmenter_assert.svh
// Assertion macros for the UTF-8 segmenter.
// Define ASSERT_OFF to compile the checks out.
`ifndef UTF8_CHAR_SEGMENTER_ASSERT_SVH
`define UTF8_CHAR_SEGMENTER_ASSERT_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clock edge outside reset.
`define U8S_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define U8S_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define U8S_ASSERT(label, prop, msg)
`define U8S_ASSERT_NEVER(label, cond, msg)

`endif

`endif

FILE: sv/u8seg_pkg.sv
package u8seg_pkg;

  // Width of the internal character counter.
  localparam int unsigned COUNT_BITS = 32;
  // Width of the character count field on the result beat.
  localparam int unsigned CNT_FIELD_BITS = 32;
  // Width wide enough to compare the counter against the field maximum.
  localparam int unsigned CNT_EXT_BITS =
    (COUNT_BITS > CNT_FIELD_BITS) ? COUNT_BITS : CNT_FIELD_BITS;

  typedef logic [COUNT_BITS-1:0] count_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEAD = 2'd1,
    ST_BAD_CONT = 2'd2,
    ST_TRUNC    = 2'd3
  } status_e;

  typedef struct packed {
    logic [31:0]               bytes;
    logic [2:0]                length;
    status_e                   status;
    logic [CNT_FIELD_BITS-1:0] count;
    logic                      eot;
  } result_t;

  // Character length from the lead byte prefix, 0 for an invalid lead.
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if ((b & 8'h80) == 8'h00) begin
      len = 3'd1;
    end else if ((b & 8'hE0) == 8'hC0) begin
      len = 3'd2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      len = 3'd3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      len = 3'd4;
    end
    return len;
  endfunction

  // Clamp the counter to the result field.
  function automatic logic [CNT_FIELD_BITS-1:0] count_field(input count_t c);
    logic [CNT_EXT_BITS-1:0] ext;
    logic [CNT_EXT_BITS-1:0] lim;
    ext = CNT_EXT_BITS'(c);
    lim = CNT_EXT_BITS'({CNT_FIELD_BITS{1'b1}});
    if (ext > lim) begin
      return '1;
    end
    return ext[CNT_FIELD_BITS-1:0];
  endfunction

endpackage

FILE: sv/utf8_char_segmenter.sv
// UTF-8 character segmenter.
//
// Input channel: one text byte per beat (text_byte_i), with last_byte_i set on
// the final byte of a text. A beat is taken when in_valid_i is high and
// in_stall_o is low. Output channel: one beat per completed character; the
// final byte ends the text on its character's beat or on a beat with the
// first error seen. A beat leaves when out_valid_o is high, out_stall_i low.
//
// Throughput is one byte per cycle while in_stall_o is low: the lead decode,
// the continuation check and the counter update are a single pass of logic
// from the state registers to the result register, or to the skid register
// while the result register is held by a stall.
//
// A result register plus one skid register sit on the output. When the
// receiver stalls, the skid register catches one more result; in_stall_o
// rises only while the skid register is full, so bytes that give no result
// keep flowing as long as there is room.
//
// Reset clears the character state, the error flag, the counter and both
// output slots. All but the output slots also clear after every final byte.
`include "utf8_char_segmenter_assert.svh"

module utf8_char_segmenter
  import u8seg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] char_bytes_o,
  output logic [2:0]  char_length_o,
  output logic [1:0]  status_o,
  output logic [31:0] char_count_o,
  output logic        end_of_text_o
);

  // Open character state.
  logic [23:0] coll_q, coll_d;
  logic [2:0]  exp_q, exp_d;
  logic [1:0]  rcv_q, rcv_d;
  count_t      chars_q, chars_d;
  status_e     err_q, err_d;

  // Output slots.
  result_t     out_q, skid_q;
  logic        out_valid_q, skid_valid_q;

  logic        accept;
  logic        out_take;
  logic        res_valid;
  result_t     res;
  count_t      chars_inc;
  logic [2:0]  lead_len;
  logic [31:0] merged;
  logic [2:0]  next_pos;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;
  assign out_take   = out_valid_q && !out_stall_i;

  assign chars_inc = (chars_q == '1) ? chars_q : chars_q + COUNT_BITS'(1);
  assign lead_len  = lead_length(text_byte_i);
  assign merged    = {8'h00, coll_q} | (32'(text_byte_i) << {rcv_q, 3'b000});
  assign next_pos  = {1'b0, rcv_q} + 3'd1;

  // Decode one byte against the open character.
  always_comb begin
    coll_d    = coll_q;
    exp_d     = exp_q;
    rcv_d     = rcv_q;
    chars_d   = chars_q;
    err_d     = err_q;
    res_valid = 1'b0;
    res       = '{bytes: '0, length: '0, status: ST_OK,
                  count: count_field(chars_q), eot: 1'b1};

    if (accept) begin
      if (err_q == ST_OK) begin
        if (exp_q == 3'd0) begin
          if (lead_len == 3'd0) begin
            err_d = ST_BAD_LEAD;
          end else if (lead_len == 3'd1) begin
            // Single-byte character: finish at once.
            res_valid  = 1'b1;
            res.bytes  = 32'(text_byte_i);
            res.length = 3'd1;
            res.count  = count_field(chars_inc);
            res.eot    = last_byte_i;
            chars_d    = chars_inc;
          end else begin
            coll_d = 24'(text_byte_i);
            exp_d  = lead_len;
            rcv_d  = 2'd1;
            if (last_byte_i) begin
              err_d = ST_TRUNC;
            end
          end
        end else if ((text_byte_i & 8'hC0) != 8'h80) begin
          err_d = ST_BAD_CONT;
        end else if (next_pos >= exp_q) begin
          // Continuation closes the character.
          res_valid  = 1'b1;
          res.bytes  = merged;
          res.length = exp_q;
          res.count  = count_field(chars_inc);
          res.eot    = last_byte_i;
          chars_d    = chars_inc;
          coll_d     = '0;
          exp_d      = '0;
          rcv_d      = '0;
        end else begin
          coll_d = merged[23:0];
          rcv_d  = next_pos[1:0];
          if (last_byte_i) begin
            err_d = ST_TRUNC;
          end
        end
      end

      // Final byte with no completed character: report the first error.
      if (last_byte_i && !res_valid) begin
        res_valid  = 1'b1;
        res.status = err_d;
      end

      // Clear everything after the final byte.
      if (last_byte_i) begin
        coll_d  = '0;
        exp_d   = '0;
        rcv_d   = '0;
        chars_d = '0;
        err_d   = ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coll_q  <= '0;
      exp_q   <= '0;
      rcv_q   <= '0;
      chars_q <= '0;
      err_q   <= ST_OK;
    end else begin
      coll_q  <= coll_d;
      exp_q   <= exp_d;
      rcv_q   <= rcv_d;
      chars_q <= chars_d;
      err_q   <= err_d;
    end
  end

  // Output slot and skid slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_take) begin
      // Result slot frees up: drain the skid first, else load the new beat.
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= res_valid;
      end
    end else if (res_valid) begin
      // Result slot held by a stall: park the new beat.
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (res_valid) begin
        out_q <= res;
      end
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign char_bytes_o  = out_q.bytes;
  assign char_length_o = out_q.length;
  assign status_o      = out_q.status;
  assign char_count_o  = out_q.count;
  assign end_of_text_o = out_q.eot;

  `U8S_ASSERT_NEVER(a_skid_without_out, skid_valid_q && !out_valid_q, "skid full with result slot empty")
  `U8S_ASSERT(a_ok_length, (out_valid_q && out_q.status == ST_OK) |-> (out_q.length != 3'd0 && out_q.length <= 3'd4), "ok beat with bad length")
  `U8S_ASSERT(a_err_shape, (out_valid_q && out_q.status != ST_OK) |-> (out_q.bytes == 32'd0 && out_q.length == 3'd0 && out_q.eot), "error beat not blank or not final")
  `U8S_ASSERT(a_clear_after_last, (accept && last_byte_i) |=> (exp_q == 3'd0 && err_q == ST_OK && chars_q == '0), "state not cleared after final byte")

endmodule

FILE: dv/utf8_char_segmenter_checker.sv
`timescale 1ns / 100ps

module utf8_char_segmenter_checker
  import u8seg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  text_byte_i,
  input  logic        last_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] char_bytes_i,
  input  logic [2:0]  char_length_i,
  input  logic [1:0]  status_i,
  input  logic [31:0] char_count_i,
  input  logic        end_of_text_i,
  output int          mismatches_o,
  output int          pending_o
);

  // Segmenter state as the byte stream leaves it.
  logic [23:0] open_bytes  = '0;
  logic [2:0]  open_len    = '0;
  logic [2:0]  open_got    = '0;
  count_t      chars_done  = '0;
  status_e     first_fault = ST_OK;

  result_t owed_beats[$];
  result_t want;

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
  end

  function automatic logic [2:0] prefix_len(input logic [7:0] b);
    casez (b)
      8'b0???????: return 3'd1;
      8'b110?????: return 3'd2;
      8'b1110????: return 3'd3;
      8'b11110???: return 3'd4;
      default:     return 3'd0;
    endcase
  endfunction

  function automatic logic [31:0] count_to_field(input count_t c);
    logic [63:0] wide;
    wide = 64'(c);
    return (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
  endfunction

  task automatic clear_text();
    open_bytes  = '0;
    open_len    = '0;
    open_got    = '0;
    chars_done  = '0;
    first_fault = ST_OK;
  endtask

  task automatic segment_byte(input logic [7:0] b, input logic last);
    result_t     r;
    logic [2:0]  n;
    logic [31:0] packed_w;
    logic [2:0]  done_len;
    logic        done;
    done     = 1'b0;
    packed_w = '0;
    done_len = '0;
    if (first_fault == ST_OK) begin
      if (open_len == 3'd0) begin
        n = prefix_len(b);
        if (n == 3'd0) begin
          first_fault = ST_BAD_LEAD;
        end else if (n == 3'd1) begin
          packed_w = {24'd0, b};
          done_len = 3'd1;
          done     = 1'b1;
        end else begin
          open_bytes = {16'd0, b};
          open_len   = n;
          open_got   = 3'd1;
          if (last) first_fault = ST_TRUNC;
        end
      end else if (b[7:6] != 2'b10) begin
        first_fault = ST_BAD_CONT;
      end else begin
        packed_w = {8'd0, open_bytes} | (32'(b) << (8 * open_got));
        if (open_got + 3'd1 >= open_len) begin
          done_len = open_len;
          done     = 1'b1;
        end else begin
          open_bytes = packed_w[23:0];
          open_got   = open_got + 3'd1;
          if (last) first_fault = ST_TRUNC;
        end
      end
    end

    if (done) begin
      if (chars_done != '1) chars_done = chars_done + 1'b1;
      r.bytes  = packed_w;
      r.length = done_len;
      r.status = ST_OK;
      r.count  = count_to_field(chars_done);
      r.eot    = last;
      owed_beats.push_back(r);
      open_bytes = '0;
      open_len   = '0;
      open_got   = '0;
      if (last) clear_text();
    end else if (last) begin
      // final byte closes the text with the first fault, or a cut character
      r.bytes  = '0;
      r.length = '0;
      r.status = first_fault;
      r.count  = count_to_field(chars_done);
      r.eot    = 1'b1;
      owed_beats.push_back(r);
      clear_text();
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s expected %h got %h", $time, what, exp_v, got_v);
      mismatches_o = mismatches_o + 1;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // drain first: a byte taken on this edge cannot have its beat out yet
      if (out_valid_i && !out_stall_i) begin
        if (owed_beats.size() == 0) begin
          $display("%0t: unexpected beat bytes %h len %0d status %0d count %0d eot %b",
                   $time, char_bytes_i, char_length_i, status_i, char_count_i,
                   end_of_text_i);
          mismatches_o = mismatches_o + 1;
        end else begin
          want = owed_beats.pop_front();
          check_field("char_bytes", want.bytes, char_bytes_i);
          check_field("char_length", 32'(want.length), 32'(char_length_i));
          check_field("status", 32'(want.status), 32'(status_i));
          check_field("char_count", want.count, char_count_i);
          check_field("end_of_text", 32'(want.eot), 32'(end_of_text_i));
        end
      end
      if (in_valid_i && !in_stall_i) segment_byte(text_byte_i, last_byte_i);
      pending_o <= owed_beats.size();
    end
  end

endmodule

FILE: dv/utf8_char_segmenter_test.sv
`timescale 1ns / 100ps

module utf8_char_segmenter_test;
  import u8seg_pkg::*;

  // Stop after roughly this many text bytes, directed ones included.
  localparam int unsigned ByteTarget = 1450;
  // Cycles with no beat on either channel before the run is declared hung.
  localparam int unsigned HangLimit  = 4000;

  typedef enum int unsigned {
    SHAPE_CLEAN,
    SHAPE_BAD_LEAD,
    SHAPE_BAD_CONT,
    SHAPE_CUT,
    SHAPE_NOISE
  } text_shape_e;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [7:0]  text_byte  = '0;
  logic        last_byte  = 1'b0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [31:0] char_bytes;
  logic [2:0]  char_length;
  logic [1:0]  status;
  logic [31:0] char_count;
  logic        end_of_text;

  int          mismatches;
  int          pending;
  int unsigned bytes_sent = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left = 0;

  logic [7:0]  text_q[$];

  always #2 clk_i = ~clk_i;

  utf8_char_segmenter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .text_byte_i   (text_byte),
    .last_byte_i   (last_byte),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .char_bytes_o  (char_bytes),
    .char_length_o (char_length),
    .status_o      (status),
    .char_count_o  (char_count),
    .end_of_text_o (end_of_text)
  );

  utf8_char_segmenter_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .text_byte_i   (text_byte),
    .last_byte_i   (last_byte),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .char_bytes_i  (char_bytes),
    .char_length_i (char_length),
    .status_i      (status),
    .char_count_i  (char_count),
    .end_of_text_i (end_of_text),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  // Pause length in cycles: mostly none or short, now and then a long one.
  function automatic int unsigned pause_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Push a lead byte for an n-byte character and then conts continuation
  // bytes; conts = n - 1 gives a whole character.
  task automatic push_char(input int unsigned n, input int unsigned conts);
    case (n)
      1:       text_q.push_back(8'($urandom_range(0, 127)));
      2:       text_q.push_back(8'hC0 | 8'($urandom_range(0, 31)));
      3:       text_q.push_back(8'hE0 | 8'($urandom_range(0, 15)));
      default: text_q.push_back(8'hF0 | 8'($urandom_range(0, 7)));
    endcase
    repeat (conts) text_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
  endtask

  // Send the queued text, one beat per byte, flag on the final one. Gaps are
  // made by dropping valid at a falling edge; a byte is held until the
  // rising edge that finds stall low.
  task automatic send_text();
    int unsigned gap;
    bit          free_run;
    free_run = ($urandom_range(0, 7) == 0);
    for (int i = 0; i < text_q.size(); i++) begin
      gap = free_run ? 0 : pause_len();
      if (gap != 0) begin
        @(negedge clk_i);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      in_valid  <= 1'b1;
      text_byte <= text_q[i];
      last_byte <= (i == text_q.size() - 1);
      do @(posedge clk_i); while (in_stall);
      bytes_sent++;
    end
    text_q.delete();
  endtask

  // Build one random text. Most are clean runs of characters; some carry a
  // bad lead or continuation at a random point or a cut character at the end
  // (a few are raw noise); bytes after a fault still exercise the drop path.
  task automatic random_text();
    text_shape_e shape;
    int unsigned pick;
    int unsigned n_chars;
    int unsigned brk;
    int unsigned n;
    pick = $urandom_range(0, 99);
    if (pick < 68)      shape = SHAPE_CLEAN;
    else if (pick < 78) shape = SHAPE_BAD_LEAD;
    else if (pick < 87) shape = SHAPE_BAD_CONT;
    else if (pick < 95) shape = SHAPE_CUT;
    else                shape = SHAPE_NOISE;

    if (shape == SHAPE_NOISE) begin
      repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom));
    end else begin
      if ($urandom_range(0, 19) == 0)  n_chars = $urandom_range(20, 60);
      else if (shape == SHAPE_CLEAN)   n_chars = $urandom_range(1, 10);
      else                             n_chars = $urandom_range(0, 8);
      // a cut character can only sit at the very end
      brk = (shape == SHAPE_CUT) ? n_chars : $urandom_range(0, n_chars);
      for (int i = 0; i <= n_chars; i++) begin
        if (i == brk) begin
          case (shape)
            SHAPE_BAD_LEAD: begin
              if ($urandom_range(0, 1) == 0)
                text_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
              else
                text_q.push_back(8'hF8 | 8'($urandom_range(0, 7)));
            end
            SHAPE_BAD_CONT: begin
              n = $urandom_range(2, 4);
              push_char(n, $urandom_range(0, n - 2));
              if ($urandom_range(0, 1) == 0)
                text_q.push_back(8'($urandom_range(0, 127)));
              else
                text_q.push_back(8'hC0 | 8'($urandom_range(0, 63)));
            end
            SHAPE_CUT: begin
              n = $urandom_range(2, 4);
              push_char(n, $urandom_range(0, n - 2));
            end
            default: ;
          endcase
        end
        if (i < n_chars) begin
          n = $urandom_range(1, 4);
          push_char(n, n - 1);
        end
      end
    end
    send_text();
  endtask

  // Receiver back-pressure: random open and stalled stretches of random
  // length, with the odd long open stretch so full-rate streaming is seen.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall <= 1'b0;
      hold_left <= $urandom_range(40, 120);
    end else begin
      out_stall <= ($urandom_range(0, 99) < 45);
      hold_left <= pause_len();
    end
  end

  // Watchdog: count cycles with no beat on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= HangLimit) begin
        $display("%0t: no beat for %0d cycles", $time, HangLimit);
        $display("[utf8_char_segmenter] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    // hold reset, release on a falling edge
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // ASCII extremes, final byte completes a one-byte character
    text_q = '{8'h00, 8'h7F};
    send_text();
    // two-byte character at its lowest value, three- and four-byte ones at their top
    text_q = '{8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_text();
    // invalid lead mid-text; drop everything up to the final byte
    text_q = '{8'h41, 8'hFF, 8'hC3, 8'h41};
    send_text();
    // final byte is itself a bad continuation
    text_q = '{8'hDF, 8'h41};
    send_text();
    // text ends inside a three-byte character
    text_q = '{8'hE0, 8'hA0};
    send_text();
    // lone continuation byte as the whole text
    text_q = '{8'hBF};
    send_text();
    // four-byte lead as the final byte
    text_q = '{8'hF7};
    send_text();
    // bad continuation mid-character, later bytes dropped
    text_q = '{8'hF0, 8'h90, 8'hC0, 8'h80};
    send_text();

    while (bytes_sent < ByteTarget) random_text();

    @(negedge clk_i);
    in_valid <= 1'b0;

    // wait for every owed beat, then a short tail to catch strays
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("[utf8_char_segmenter] OK");
    end else begin
      $display("[utf8_char_segmenter] ERROR");
    end
    $finish;
  end

endmodule
